@@ rtl/core/alle_pkg.sv @@
package alle_pkg;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int LINK_W     = 5;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 5;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    typedef enum logic [2:0] {
        CMD_ADD_FIRST = 3'd0,
        CMD_ADD_AFTER = 3'd1,
        CMD_ADD_LAST  = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_AFTER = 3'd4,
        CMD_DEL_LAST  = 3'd5,
        CMD_CLEAR     = 3'd6,
        CMD_TRAVERSE  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADSL = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] payload;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [DATA_W-1:0] data_out;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_out;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FREE,
        BS_WALK,
        BS_EXEC,
        BS_TRAV
    } t_bstate;
endpackage

@@ rtl/core/alle_front.sv @@
module alle_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  alle_pkg::t_in  i_item,
    input  logic           i_pop,
    output logic           o_busy,
    output logic           o_valid,
    output alle_pkg::t_in  o_item
);
    import alle_pkg::*;

    // two-entry queue between command port and executor
    t_in        r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end
endmodule

@@ rtl/core/alle_back.sv @@
module alle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  alle_pkg::t_in  i_item,
    output logic           o_pop,
    output logic           o_strobe,
    output alle_pkg::t_out o_result
);
    import alle_pkg::*;

    t_bstate r_st, n_st;
    t_in     r_it;
    logic [LINK_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [SLOTS-1:0]  r_used;
    logic [LINK_W-1:0] r_link [SLOTS];
    logic [DATA_W-1:0] r_data [SLOTS];
    logic [LINK_W-1:0] r_cur, r_prev, r_free;
    logic [CNT_W-1:0]  r_k;
    logic              r_strobe;
    t_out              r_res;

    logic [SLOT_W-1:0] cur_i;
    logic [LINK_W-1:0] nx;
    logic              is_add;

    assign cur_i    = r_cur[SLOT_W-1:0];
    assign nx       = r_link[cur_i];
    assign o_pop    = (r_st == BS_IDLE) && i_valid;
    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign is_add   = (r_it.cmd == CMD_ADD_FIRST) || (r_it.cmd == CMD_ADD_AFTER)
                      || (r_it.cmd == CMD_ADD_LAST);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BS_IDLE: if (i_valid) n_st = BS_FREE;
            BS_FREE: begin
                // free slot scan one entry per cycle, then tail walk if needed
                if (is_add && !r_used[r_free[SLOT_W-1:0]] && r_free != NIL) begin
                    n_st = BS_WALK;
                end else if (!is_add || r_free == NIL || r_free == LINK_W'(SLOTS - 1)) begin
                    n_st = BS_WALK;
                end
            end
            BS_WALK: begin
                if (r_it.cmd == CMD_TRAVERSE) n_st = BS_TRAV;
                else if (r_it.cmd == CMD_ADD_LAST || r_it.cmd == CMD_DEL_LAST) begin
                    if (r_cur == NIL) n_st = BS_EXEC;
                    else if (r_it.cmd == CMD_ADD_LAST) n_st = BS_WALK;
                    else if (nx == NIL) n_st = BS_EXEC;
                end else n_st = BS_EXEC;
            end
            BS_EXEC: n_st = BS_IDLE;
            BS_TRAV: if (r_cur == NIL || nx == NIL || r_k == CNT_W'(SLOTS - 1)) n_st = BS_IDLE;
            default: n_st = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [LINK_W-1:0] pred, v;
        logic [SLOT_W-1:0] n_i;
        r_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_st    <= BS_IDLE;
            r_head  <= NIL;
            r_count <= '0;
            r_used  <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                BS_IDLE: if (i_valid) begin
                    r_it   <= i_item;
                    r_free <= '0;
                    r_cur  <= r_head;
                    r_prev <= NIL;
                    r_k    <= '0;
                end
                BS_FREE: begin
                    if (!(is_add && !r_used[r_free[SLOT_W-1:0]] && r_free != NIL)) begin
                        if (r_free == LINK_W'(SLOTS - 1) || r_free == NIL) r_free <= NIL;
                        else if (is_add) r_free <= r_free + 1'b1;
                    end
                end
                BS_WALK: begin
                    if (r_it.cmd == CMD_ADD_LAST && r_cur != NIL) begin
                        r_prev <= r_cur;
                        r_cur  <= nx;
                    end else if (r_it.cmd == CMD_DEL_LAST && r_cur != NIL && nx != NIL) begin
                        r_prev <= r_cur;
                        r_cur  <= nx;
                    end else if (r_it.cmd == CMD_TRAVERSE && r_head == NIL) begin
                        r_strobe <= 1'b1;
                        r_res    <= '{ST_EMPTY, '0, '0, r_count, 1'b1};
                    end
                end
                BS_EXEC: begin
                    r_strobe <= 1'b1;
                    r_res    <= '{ST_OK, '0, '0, r_count, 1'b1};
                    n_i = r_free[SLOT_W-1:0];
                    priority case (1'b1)
                        r_it.cmd == CMD_CLEAR: begin
                            r_head  <= NIL;
                            r_count <= '0;
                            r_used  <= '0;
                            r_res.count <= '0;
                        end
                        is_add: begin
                            pred = (r_it.cmd == CMD_ADD_FIRST) ? NIL :
                                   (r_it.cmd == CMD_ADD_AFTER) ? {1'b0, r_it.slot} : r_prev;
                            if (r_count == CNT_W'(SLOTS) || r_free == NIL) begin
                                r_res.status <= ST_FULL;
                            end else if (r_it.cmd == CMD_ADD_AFTER && !r_used[r_it.slot]) begin
                                r_res.status <= ST_BADSL;
                            end else begin
                                r_used[n_i] <= 1'b1;
                                r_data[n_i] <= r_it.payload;
                                if (pred == NIL) begin
                                    r_link[n_i] <= r_head;
                                    r_head      <= r_free;
                                end else begin
                                    r_link[n_i] <= r_link[pred[SLOT_W-1:0]];
                                    r_link[pred[SLOT_W-1:0]] <= r_free;
                                end
                                r_count <= r_count + 1'b1;
                                r_res   <= '{ST_OK, n_i, r_it.payload, r_count + 1'b1, 1'b1};
                            end
                        end
                        default: begin
                            pred = (r_it.cmd == CMD_DEL_FIRST) ? NIL :
                                   (r_it.cmd == CMD_DEL_AFTER) ? {1'b0, r_it.slot} : r_prev;
                            if (r_it.cmd == CMD_DEL_AFTER && !r_used[r_it.slot]) begin
                                r_res.status <= ST_BADSL;
                            end else begin
                                v = (pred == NIL) ? r_head : r_link[pred[SLOT_W-1:0]];
                                if (v == NIL) begin
                                    r_res.status <= ST_EMPTY;
                                end else begin
                                    if (pred == NIL) r_head <= r_link[v[SLOT_W-1:0]];
                                    else r_link[pred[SLOT_W-1:0]] <= r_link[v[SLOT_W-1:0]];
                                    r_used[v[SLOT_W-1:0]] <= 1'b0;
                                    r_count <= r_count - 1'b1;
                                    r_res <= '{ST_OK, v[SLOT_W-1:0], r_data[v[SLOT_W-1:0]],
                                               r_count - 1'b1, 1'b1};
                                end
                            end
                        end
                    endcase
                end
                BS_TRAV: begin
                    if (r_cur != NIL) begin
                        r_strobe <= 1'b1;
                        r_res    <= '{ST_OK, cur_i, r_data[cur_i], r_count,
                                      (nx == NIL) || (r_k == CNT_W'(SLOTS - 1))};
                        r_cur    <= nx;
                        r_k      <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/core/array_linked_list_engine_core.sv @@
// Adds scan free slots one per cycle, add/delete last walk the list one link
// per cycle. Traverse emits one result per cycle. Throughput: one command at a
// time in the executor, two more queued. Reset (synchronous, active low)
// empties the list and the queue. The receiver cannot stall: each result
// strobes once.
module array_linked_list_engine_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  alle_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output alle_pkg::t_out o_result
);
    import alle_pkg::*;

    // queue handoff between front and back
    logic q_valid, q_pop;
    t_in  q_item;

    alle_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_item),
        .i_pop  (q_pop),
        .o_busy (busy),
        .o_valid(q_valid),
        .o_item (q_item)
    );

    alle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );
endmodule

@@ test/array_linked_list_engine_core_tb.sv @@
`timescale 1ns / 100ps

module array_linked_list_engine_core_tb;
    import alle_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_strobe;
    t_out o_result;

    array_linked_list_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // 20 ns clock, high and low halves
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Shadow copy of the list, updated as each transaction is accepted
    logic [LINK_W-1:0] sh_head;
    logic [LINK_W-1:0] sh_link [SLOTS];
    logic              sh_used [SLOTS];
    logic [DATA_W-1:0] sh_data [SLOTS];
    int                sh_count;

    t_out result_q [$];
    int   err_cnt;
    int   got_cnt;
    int   sent_cnt;
    int   trav_rows;
    int   full_hits;
    int   bad_hits;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0h want %0h", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic t_out mk_result(input t_status st, input int idx,
                                       input logic [DATA_W-1:0] d, input bit lst);
        t_out r;
        r.status     = st;
        r.slot_index = idx[SLOT_W-1:0];
        r.data_out   = d;
        r.count      = sh_count[CNT_W-1:0];
        r.last       = lst;
        return r;
    endfunction

    function automatic void list_reset();
        sh_head  = NIL;
        sh_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            sh_used[i] = 1'b0;
            sh_link[i] = '0;
            sh_data[i] = '0;
        end
    endfunction

    // Insert after pred (NIL means at head); push the expected result
    function automatic void list_insert(input int pred, input logic [DATA_W-1:0] d);
        int n;
        n = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!sh_used[i]) n = i;
        if (n >= SLOTS) begin
            full_hits++;
            result_q.push_back(mk_result(ST_FULL, 0, '0, 1'b1));
            return;
        end
        sh_used[n] = 1'b1;
        sh_data[n] = d;
        if (pred >= SLOTS) begin
            sh_link[n] = sh_head;
            sh_head    = LINK_W'(n);
        end else begin
            sh_link[n]    = sh_link[pred];
            sh_link[pred] = LINK_W'(n);
        end
        sh_count++;
        result_q.push_back(mk_result(ST_OK, n, d, 1'b1));
    endfunction

    function automatic void list_remove(input int pred);
        int v;
        v = (pred >= SLOTS) ? int'(sh_head) : int'(sh_link[pred]);
        if (v >= SLOTS) begin
            result_q.push_back(mk_result(ST_EMPTY, 0, '0, 1'b1));
            return;
        end
        if (pred >= SLOTS) sh_head = sh_link[v];
        else sh_link[pred] = sh_link[v];
        sh_used[v] = 1'b0;
        sh_count--;
        result_q.push_back(mk_result(ST_OK, v, sh_data[v], 1'b1));
    endfunction

    // Work out the results of one accepted command
    function automatic void predict_command(input t_in it);
        int cur;
        int prev;
        int nx;
        int k;
        case (t_cmd'(it.cmd))
            CMD_ADD_FIRST: list_insert(SLOTS, it.payload);
            CMD_ADD_AFTER: begin
                if (sh_count >= SLOTS) list_insert(SLOTS, it.payload);
                else if (!sh_used[it.slot]) begin
                    bad_hits++;
                    result_q.push_back(mk_result(ST_BADSL, 0, '0, 1'b1));
                end else list_insert(it.slot, it.payload);
            end
            CMD_ADD_LAST: begin
                cur  = sh_head;
                prev = SLOTS;
                for (int s = 0; cur < SLOTS && s < SLOTS; s++) begin
                    prev = cur;
                    cur  = sh_link[cur];
                end
                list_insert(prev, it.payload);
            end
            CMD_DEL_FIRST: list_remove(SLOTS);
            CMD_DEL_AFTER: begin
                if (!sh_used[it.slot]) begin
                    bad_hits++;
                    result_q.push_back(mk_result(ST_BADSL, 0, '0, 1'b1));
                end else list_remove(it.slot);
            end
            CMD_DEL_LAST: begin
                prev = SLOTS;
                if (sh_head < SLOTS) begin
                    cur = sh_head;
                    for (int s = 0; s < SLOTS; s++) begin
                        nx = sh_link[cur];
                        if (nx >= SLOTS) break;
                        prev = cur;
                        cur  = nx;
                    end
                end
                list_remove(prev);
            end
            CMD_CLEAR: begin
                list_reset();
                result_q.push_back(mk_result(ST_OK, 0, '0, 1'b1));
            end
            default: begin
                if (sh_head >= SLOTS)
                    result_q.push_back(mk_result(ST_EMPTY, 0, '0, 1'b1));
                else begin
                    k   = 0;
                    cur = sh_head;
                    while (cur < SLOTS && k < SLOTS) begin
                        nx = sh_link[cur];
                        result_q.push_back(mk_result(ST_OK, cur, sh_data[cur],
                                                     (nx >= SLOTS || k + 1 >= SLOTS)));
                        trav_rows++;
                        k++;
                        cur = nx;
                    end
                end
            end
        endcase
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            got_cnt++;
            if (result_q.size() == 0) begin
                $display("MISMATCH at %0t: result with nothing expected", $time);
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.slot_index !== want.slot_index)
                    report_mismatch("slot_index", o_result.slot_index, want.slot_index);
                if (o_result.data_out !== want.data_out)
                    report_mismatch("data_out", o_result.data_out, want.data_out);
                if (o_result.count !== want.count)
                    report_mismatch("count", o_result.count, want.count);
                if (o_result.last !== want.last)
                    report_mismatch("last", o_result.last, want.last);
            end
        end
    end

    // Hold start until the transaction is taken, then predict it
    task automatic send_command(input t_in it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(it);
        sent_cnt++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_in mk_cmd(input t_cmd c, input int s, input logic [DATA_W-1:0] d);
        t_in it;
        it.cmd     = c;
        it.slot    = s[SLOT_W-1:0];
        it.payload = d;
        return it;
    endfunction

    // Pick a slot that is mostly in the list, sometimes any
    function automatic int pick_slot();
        int cand [$];
        for (int i = 0; i < SLOTS; i++)
            if (sh_used[i]) cand.push_back(i);
        if (cand.size() == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, SLOTS - 1);
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Directed rows: expectation typed in where it is plain, else predicted
    typedef struct {
        t_in  item;
        bit   fixed;
        t_out want;
    } t_row;

    t_row rows [$];

    function automatic t_out fixed_out(input t_status st, input int idx,
                                       input logic [DATA_W-1:0] d, input int cnt);
        t_out r;
        r.status     = st;
        r.slot_index = idx[SLOT_W-1:0];
        r.data_out   = d;
        r.count      = cnt[CNT_W-1:0];
        r.last       = 1'b1;
        return r;
    endfunction

    initial begin
        #20_000_000;
        $display("timeout");
        $display("array_linked_list_engine_core_tb failed");
        $finish;
    end

    initial begin
        t_in  it;
        t_out w;
        int   c;
        err_cnt   = 0;
        got_cnt   = 0;
        sent_cnt  = 0;
        trav_rows = 0;
        full_hits = 0;
        bad_hits  = 0;
        list_reset();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-list cases after reset, then a short build-up and tear-down
        rows.push_back('{mk_cmd(CMD_TRAVERSE, 0, '0), 1, fixed_out(ST_EMPTY, 0, '0, 0)});
        rows.push_back('{mk_cmd(CMD_DEL_FIRST, 0, '0), 1, fixed_out(ST_EMPTY, 0, '0, 0)});
        rows.push_back('{mk_cmd(CMD_DEL_LAST, 0, '0), 1, fixed_out(ST_EMPTY, 0, '0, 0)});
        rows.push_back('{mk_cmd(CMD_DEL_AFTER, 15, '0), 1, fixed_out(ST_BADSL, 0, '0, 0)});
        rows.push_back('{mk_cmd(CMD_ADD_AFTER, 3, '1), 1, fixed_out(ST_BADSL, 0, '0, 0)});
        rows.push_back('{mk_cmd(CMD_ADD_FIRST, 9, '1), 1, fixed_out(ST_OK, 0, '1, 1)});
        rows.push_back('{mk_cmd(CMD_ADD_LAST, 0, '0), 1, fixed_out(ST_OK, 1, '0, 2)});
        rows.push_back('{mk_cmd(CMD_ADD_AFTER, 0, 32'hA5A5_5A5A), 0, '0});
        rows.push_back('{mk_cmd(CMD_TRAVERSE, 0, '0), 0, '0});
        rows.push_back('{mk_cmd(CMD_DEL_AFTER, 1, '0), 1, fixed_out(ST_EMPTY, 0, '0, 3)});
        rows.push_back('{mk_cmd(CMD_DEL_AFTER, 0, '0), 0, '0});
        rows.push_back('{mk_cmd(CMD_DEL_LAST, 0, '0), 0, '0});
        rows.push_back('{mk_cmd(CMD_DEL_FIRST, 0, '0), 0, '0});
        // Fill to the top, then every add reports full
        for (int i = 0; i < SLOTS; i++)
            rows.push_back('{mk_cmd(CMD_ADD_LAST, 0, 32'h8000_0000 >> i), 0, '0});
        rows.push_back('{mk_cmd(CMD_ADD_AFTER, 7, '1), 1, fixed_out(ST_FULL, 0, '0, 16)});
        rows.push_back('{mk_cmd(CMD_ADD_FIRST, 0, '1), 1, fixed_out(ST_FULL, 0, '0, 16)});
        rows.push_back('{mk_cmd(CMD_TRAVERSE, 0, '0), 0, '0});
        rows.push_back('{mk_cmd(CMD_CLEAR, 5, '1), 1, fixed_out(ST_OK, 0, '0, 0)});

        foreach (rows[r]) begin
            send_command(rows[r].item);
            if (rows[r].fixed) begin
                // fixed rows give one result, the newest expectation
                w = result_q[result_q.size() - 1];
                if (w !== rows[r].want) begin
                    $display("MISMATCH at %0t: directed row %0d disagrees with prediction",
                             $time, r);
                    err_cnt++;
                end
            end
            idle_gap();
        end

        // Random part: mostly adds and deletes on live slots, some noise
        for (int n = 0; n < 120; n++) begin
            c = $urandom_range(0, 99);
            if (c < 35)
                it = mk_cmd(t_cmd'($urandom_range(0, 2)), pick_slot(), $urandom());
            else if (c < 65)
                it = mk_cmd(t_cmd'($urandom_range(3, 5)), pick_slot(), $urandom());
            else if (c < 85)
                it = mk_cmd(CMD_TRAVERSE, $urandom_range(0, 15), $urandom());
            else if (c < 88)
                it = mk_cmd(CMD_CLEAR, $urandom_range(0, 15), $urandom());
            else
                it = mk_cmd(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom());
            send_command(it);
            if (n == 60) begin
                // Drain everything before going on
                start <= 1'b0;
                while (result_q.size() != 0) @(posedge i_clk);
            end else begin
                idle_gap();
            end
        end
        start <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d commands, checked %0d results (%0d traverse rows).",
                 sent_cnt, got_cnt, trav_rows);
        $display("Full adds: %0d, bad slot commands: %0d.", full_hits, bad_hits);
        if (err_cnt == 0 && result_q.size() == 0)
            $display("array_linked_list_engine_core_tb passed");
        else
            $display("array_linked_list_engine_core_tb failed");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/alle_pkg.sv
rtl/core/alle_front.sv
rtl/core/alle_back.sv
rtl/core/array_linked_list_engine_core.sv
test/array_linked_list_engine_core_tb.sv
